// ===== hdl/tlwf_pkg.sv =====
// ----------------------------------------------------------------------------
// tlwf_pkg
// shared constants and helpers for the text line wrap formatter
// ----------------------------------------------------------------------------
package tlwf_pkg;

	localparam int WORD_DEPTH = 64;
	localparam int WA_W       = $clog2(WORD_DEPTH);
	localparam int WL_W       = WA_W + 1;
	localparam int MAX_OUT    = 64;

	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [5:0] INDENT_MAX = 6'd62;

	localparam logic [2:0] REG_INDENT = 3'd0;
	localparam logic [2:0] REG_LINE   = 3'd1;
	localparam logic [2:0] REG_PAGE   = 3'd2;
	localparam logic [2:0] REG_WRAP   = 3'd3;
	localparam logic [2:0] REG_MERGE  = 3'd4;
	localparam logic [2:0] REG_PBCODE = 3'd5;

	// continuation bytes that follow a lead byte
	function automatic logic [1:0] utf8_cont(input logic [7:0] b);
		logic [1:0] n;
		n = 2'd0;
		if ((b & 8'hE0) == 8'hC0) n = 2'd1;
		else if ((b & 8'hF0) == 8'hE0) n = 2'd2;
		else if ((b & 8'hF8) == 8'hF0) n = 2'd3;
		return n;
	endfunction

	function automatic logic is_word_byte(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
			c == 8'h2D || c == 8'h2C || c == 8'h2E || c == 8'h3A ||
			c == 8'h22 || c == 8'h27;
	endfunction

endpackage

// ===== hdl/tlwf_word_ram.sv =====
// ----------------------------------------------------------------------------
// tlwf_word_ram
// held word bytes, one write port, one registered read port
// ----------------------------------------------------------------------------
module tlwf_word_ram import tlwf_pkg::*; (
	input  logic            clk,
	input  logic            we,
	input  logic [WA_W-1:0] waddr,
	input  logic [7:0]      wdata,
	input  logic [WA_W-1:0] raddr,
	output logic [7:0]      rdata
);

	logic [7:0] mem [WORD_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/text_line_wrap_formatter.sv =====
// ----------------------------------------------------------------------------
// text_line_wrap_formatter
// streaming utf-8 text formatter with indent, line wrap and paging
// ----------------------------------------------------------------------------
// Input channel in_valid/in_stall carries one source byte per transfer with
// end_of_text on the final byte. Output channel out_valid/out_stall carries
// formatted bytes; run_last marks the last byte caused by one input byte.
// An input byte may cause no output at all.
// One byte is processed at a time: in_stall is high from the transfer until
// its last result is handed to the output register. A flush reads each held
// word byte through the single registered read port of the word store and
// then emits it. A stalled receiver holds the output register and the
// sequencer waits. Reset (arst_n low) clears the stream state and loads
// register defaults; the word store needs no clearing. Registers sit at
// byte address 4*i on the apb port; the user must write them only while
// the block is idle, and the block itself does not enforce it.
// ----------------------------------------------------------------------------
module text_line_wrap_formatter import tlwf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       end_of_text,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       run_last,
	input  logic       psel,
	input  logic       penable,
	input  logic       pwrite,
	input  logic [4:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic       pready
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_INDENT = 3'd1;
	localparam logic [2:0] S_FLUSH  = 3'd2;
	localparam logic [2:0] S_BYTE   = 3'd3;
	localparam logic [2:0] S_CHECK  = 3'd4;
	localparam logic [2:0] S_CODE   = 3'd5;
	localparam logic [2:0] S_TAIL   = 3'd6;
	localparam logic [2:0] S_END    = 3'd7;

	logic [5:0] indent_q, limit_q;
	logic [9:0] page_q;
	logic       wrap_q, merge_q;
	logic [7:0] pbcode_q;

	logic [2:0]      st_q, ret_q;
	logic [WL_W-1:0] wl_q, fi_q;
	logic [6:0]      lc_q, ecnt_q;
	logic [10:0]     plc_q;
	logic [1:0]      nr_q, cl_q;
	logic            ss_q, ls_q;
	logic [7:0]      b_q, code_q;
	logic            eot_q, ph_q;
	logic            f_flush_q, f_byte_q, f_store_q, f_count_q;
	logic [5:0]      cnt_q;
	logic [7:0]      hold_q;
	logic            hold_v_q, out_v_q;
	logic [7:0]      rdata;

	logic cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		unique case (paddr[4:2])
			REG_INDENT: prdata = {26'd0, indent_q};
			REG_LINE:   prdata = {26'd0, limit_q};
			REG_PAGE:   prdata = {22'd0, page_q};
			REG_WRAP:   prdata = {31'd0, wrap_q};
			REG_MERGE:  prdata = {31'd0, merge_q};
			REG_PBCODE: prdata = {24'd0, pbcode_q};
			default:    prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			indent_q <= 6'd4;
			limit_q  <= 6'd62;
			page_q   <= 10'd50;
			wrap_q   <= 1'b1;
			merge_q  <= 1'b1;
			pbcode_q <= 8'd12;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				REG_INDENT: indent_q <= pwdata[5:0];
				REG_LINE:   limit_q  <= pwdata[5:0];
				REG_PAGE:   page_q   <= pwdata[9:0];
				REG_WRAP:   wrap_q   <= pwdata[0];
				REG_MERGE:  merge_q  <= pwdata[0];
				REG_PBCODE: pbcode_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// classification of the incoming byte
	logic       acc, blank, wordb, dropped, ovf;
	logic [1:0] cont, cl_dec;
	logic [5:0] ind;
	logic       out_free, adv, em_req;
	logic [7:0] em_byte;
	logic       pb, brk_early;
	logic       st_we;

	assign in_stall = (st_q != S_IDLE);
	assign acc      = in_valid && !in_stall;
	assign blank    = (in_byte == CH_SPACE) || (in_byte == CH_TAB);
	assign wordb    = is_word_byte(in_byte);
	assign cont     = utf8_cont(in_byte);
	assign cl_dec   = end_of_text ? 2'd0 : cl_q - 2'd1;
	assign dropped  = (in_byte == pbcode_q) || (blank && ls_q) ||
		(in_byte == CH_SPACE && merge_q && ss_q);
	assign ind      = (indent_q > INDENT_MAX) ? INDENT_MAX : indent_q;
	assign ovf      = (ecnt_q >= 7'(MAX_OUT));

	assign out_free = !out_v_q || !out_stall;
	assign adv      = !hold_v_q || out_free;
	assign pb       = (page_q != 10'd0) && (plc_q >= {1'b0, page_q});
	assign brk_early = !wrap_q || (wl_q > {1'b0, limit_q});
	assign st_we    = (st_q == S_BYTE) && f_store_q;

	always_comb begin
		em_req  = 1'b0;
		em_byte = CH_SPACE;
		unique case (st_q)
			S_INDENT: em_req = (cnt_q != 6'd0);
			S_FLUSH: begin
				em_req  = (fi_q < wl_q) && ph_q;
				em_byte = rdata;
			end
			S_BYTE: begin
				em_req  = f_byte_q;
				em_byte = b_q;
			end
			S_CODE: begin
				em_req  = 1'b1;
				em_byte = code_q;
			end
			default: ;
		endcase
	end

	tlwf_word_ram u_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr (wl_q[WA_W-1:0]),
		.wdata (b_q),
		.raddr (fi_q[WA_W-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= S_IDLE;
			ret_q    <= S_IDLE;
			wl_q     <= '0;
			fi_q     <= '0;
			lc_q     <= '0;
			ecnt_q   <= '0;
			plc_q    <= 11'd1;
			nr_q     <= '0;
			cl_q     <= '0;
			ss_q     <= 1'b0;
			ls_q     <= 1'b1;
			ph_q     <= 1'b0;
			hold_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (out_v_q && !out_stall) begin
				out_v_q <= 1'b0;
			end
			if (em_req && adv && !ovf) begin
				if (hold_v_q) begin
					out_v_q  <= 1'b1;
					out_byte <= hold_q;
					run_last <= 1'b0;
				end
				hold_q   <= em_byte;
				hold_v_q <= 1'b1;
				ecnt_q   <= ecnt_q + 7'd1;
			end
			unique case (st_q)
				S_IDLE: begin
					if (acc) begin
						b_q       <= in_byte;
						eot_q     <= end_of_text;
						ecnt_q    <= '0;
						cnt_q     <= '0;
						f_flush_q <= 1'b0;
						f_byte_q  <= 1'b0;
						f_store_q <= 1'b0;
						f_count_q <= 1'b0;
						st_q      <= S_INDENT;
						if (cl_q != 2'd0) begin
							cl_q      <= cl_dec;
							f_byte_q  <= 1'b1;
							f_count_q <= (cl_dec == 2'd0);
						end else if (in_byte == CH_NL) begin
							lc_q      <= '0;
							ls_q      <= 1'b1;
							ss_q      <= 1'b0;
							f_flush_q <= 1'b1;
							if (nr_q < 2'd2) begin
								nr_q     <= nr_q + 2'd1;
								f_byte_q <= 1'b1;
								if (plc_q < 11'd2047) plc_q <= plc_q + 11'd1;
							end
						end else begin
							nr_q <= '0;
							if (!dropped) begin
								if (in_byte == CH_SPACE && merge_q) ss_q <= 1'b1;
								else if (!blank) ss_q <= 1'b0;
								if (ls_q) begin
									cnt_q <= ind;
									lc_q  <= {1'b0, ind};
									ls_q  <= 1'b0;
								end
								if (cont != 2'd0) begin
									f_flush_q <= 1'b1;
									f_byte_q  <= 1'b1;
									cl_q      <= end_of_text ? 2'd0 : cont;
									f_count_q <= end_of_text;
								end else if (wordb) begin
									f_flush_q <= (wl_q >= WL_W'(WORD_DEPTH));
									f_store_q <= 1'b1;
									f_count_q <= 1'b1;
								end else begin
									f_flush_q <= 1'b1;
									f_byte_q  <= 1'b1;
									f_count_q <= 1'b1;
								end
							end
						end
					end
				end
				S_INDENT: begin
					if (cnt_q == 6'd0) begin
						fi_q <= '0;
						ph_q <= 1'b0;
						if (f_flush_q) begin
							st_q  <= S_FLUSH;
							ret_q <= S_BYTE;
						end else begin
							st_q <= S_BYTE;
						end
					end else if (adv) begin
						cnt_q <= cnt_q - 6'd1;
					end
				end
				S_FLUSH: begin
					if (fi_q >= wl_q) begin
						wl_q <= '0;
						st_q <= ret_q;
					end else if (!ph_q) begin
						ph_q <= 1'b1;
					end else if (adv) begin
						fi_q <= fi_q + WL_W'(1);
						ph_q <= 1'b0;
					end
				end
				S_BYTE: begin
					if (!f_byte_q || adv) begin
						if (f_store_q) wl_q <= wl_q + WL_W'(1);
						if (f_count_q) begin
							if (lc_q < 7'd127) lc_q <= lc_q + 7'd1;
							st_q <= S_CHECK;
						end else begin
							st_q <= S_TAIL;
						end
					end
				end
				S_CHECK: begin
					fi_q <= '0;
					ph_q <= 1'b0;
					if (lc_q < {1'b0, limit_q}) begin
						st_q <= S_TAIL;
					end else begin
						code_q <= pb ? pbcode_q : CH_NL;
						if (pb) plc_q <= 11'd1;
						else if (plc_q < 11'd2047) plc_q <= plc_q + 11'd1;
						if (brk_early) begin
							lc_q  <= '0;
							st_q  <= S_FLUSH;
							ret_q <= S_CODE;
						end else begin
							lc_q <= wl_q;
							st_q <= S_CODE;
						end
					end
				end
				S_CODE: begin
					if (adv) begin
						fi_q  <= '0;
						ph_q  <= 1'b0;
						st_q  <= S_FLUSH;
						ret_q <= S_TAIL;
					end
				end
				S_TAIL: begin
					fi_q <= '0;
					ph_q <= 1'b0;
					if (eot_q) begin
						lc_q  <= '0;
						plc_q <= 11'd1;
						nr_q  <= '0;
						ss_q  <= 1'b0;
						ls_q  <= 1'b1;
						cl_q  <= '0;
						st_q  <= S_FLUSH;
						ret_q <= S_END;
					end else begin
						st_q <= S_END;
					end
				end
				S_END: begin
					if (!hold_v_q) begin
						st_q <= S_IDLE;
					end else if (out_free) begin
						out_v_q  <= 1'b1;
						out_byte <= hold_q;
						run_last <= 1'b1;
						hold_v_q <= 1'b0;
						st_q     <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_v_q;

endmodule

// ===== dv/text_line_wrap_formatter_tb.sv =====
// ----------------------------------------------------------------------------
// text_line_wrap_formatter_tb
// self-checking bench for the text line wrap formatter: directed table, then
// random word-heavy text under several register settings and idling phases
// ----------------------------------------------------------------------------
module text_line_wrap_formatter_tb;
	import tlwf_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_CYCLES = 20000;
	localparam int DRAIN_CYCLES    = 300;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} fmt_byte_t;

	typedef struct {
		logic [7:0] b;
		logic       eot;
		int         want;    // -1: use predictor only, else expected byte count
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  in_byte;
	logic        end_of_text;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  out_byte;
	logic        run_last;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	text_line_wrap_formatter uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte),
		.end_of_text(end_of_text),
		.out_valid(out_valid), .out_stall(out_stall), .out_byte(out_byte),
		.run_last(run_last),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// register copies
	logic [5:0] cfg_indent, cfg_line;
	logic [9:0] cfg_page;
	logic       cfg_wrap, cfg_merge;
	logic [7:0] cfg_pbcode;

	// stream state copies
	logic [7:0] held_word [WORD_DEPTH];
	int         held_len, col, page_lines, nl_run, sp_seen, at_line_start, cont_left;

	fmt_byte_t  pending_bytes [$];
	int         errors;
	int         idle_cycles;
	int         in_idle_pct, out_stall_pct;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic void push_byte(input logic [7:0] c);
		fmt_byte_t e;
		e.ch = c;
		e.last = 1'b0;
		pending_bytes.push_back(e);
	endfunction

	function automatic void flush_held();
		for (int i = 0; i < held_len; i++) push_byte(held_word[i]);
		held_len = 0;
	endfunction

	function automatic void bump_col();
		if (col < 127) col++;
	endfunction

	function automatic void bump_page();
		if (page_lines < 2047) page_lines++;
	endfunction

	function automatic void line_break_check();
		logic pb;
		logic [7:0] code;
		if (col < cfg_line) return;
		pb = cfg_page != 0 && page_lines >= cfg_page;
		code = pb ? cfg_pbcode : CH_NL;
		if (!cfg_wrap || held_len > cfg_line) begin
			flush_held();
			push_byte(code);
			col = 0;
		end else begin
			col = held_len;
			push_byte(code);
			flush_held();
		end
		if (pb) page_lines = 1;
		else bump_page();
	endfunction

	function automatic void clear_stream();
		held_len = 0;
		col = 0;
		page_lines = 1;
		nl_run = 0;
		sp_seen = 0;
		at_line_start = 1;
		cont_left = 0;
	endfunction

	// returns number of bytes queued for this transfer
	function automatic int format_byte(input logic [7:0] b, input logic eot);
		int base;
		logic blank;
		int n, ind;
		base = pending_bytes.size();
		blank = (b == CH_SPACE || b == CH_TAB);
		if (cont_left > 0) begin
			push_byte(b);
			cont_left--;
			if (eot) cont_left = 0;
			if (cont_left == 0) begin
				bump_col();
				line_break_check();
			end
		end else if (b == CH_NL) begin
			flush_held();
			col = 0;
			at_line_start = 1;
			sp_seen = 0;
			if (nl_run < 2) begin
				nl_run++;
				push_byte(CH_NL);
				bump_page();
			end
		end else begin
			nl_run = 0;
			if (!(b == cfg_pbcode || (blank && at_line_start) ||
				(b == CH_SPACE && cfg_merge && sp_seen))) begin
				if (b == CH_SPACE && cfg_merge) sp_seen = 1;
				else if (!blank) sp_seen = 0;
				if (at_line_start) begin
					ind = cfg_indent > INDENT_MAX ? int'(INDENT_MAX) : int'(cfg_indent);
					for (int k = 0; k < ind; k++) begin
						push_byte(CH_SPACE);
						bump_col();
					end
					at_line_start = 0;
				end
				n = 0;
				if ((b & 8'hE0) == 8'hC0) n = 1;
				else if ((b & 8'hF0) == 8'hE0) n = 2;
				else if ((b & 8'hF8) == 8'hF0) n = 3;
				if (n > 0) begin
					flush_held();
					push_byte(b);
					cont_left = n;
					if (eot) begin
						cont_left = 0;
						bump_col();
						line_break_check();
					end
				end else if ((b >= "a" && b <= "z") || (b >= "A" && b <= "Z") ||
					b == "-" || b == "," || b == "." || b == ":" ||
					b == 8'h22 || b == 8'h27) begin
					if (held_len >= WORD_DEPTH) flush_held();
					held_word[held_len] = b;
					held_len++;
					bump_col();
					line_break_check();
				end else begin
					flush_held();
					push_byte(b);
					bump_col();
					line_break_check();
				end
			end
		end
		if (eot) begin
			flush_held();
			clear_stream();
		end
		if (pending_bytes.size() > base)
			pending_bytes[pending_bytes.size() - 1].last = 1'b1;
		return pending_bytes.size() - base;
	endfunction

	task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
		@(negedge clk);
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = {idx, 2'b00};
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		case (idx)
			REG_INDENT: cfg_indent = val[5:0];
			REG_LINE:   cfg_line = val[5:0];
			REG_PAGE:   cfg_page = val[9:0];
			REG_WRAP:   cfg_wrap = val[0];
			REG_MERGE:  cfg_merge = val[0];
			REG_PBCODE: cfg_pbcode = val[7:0];
			default: ;
		endcase
	endtask

	task automatic set_regs(input int ind, input int lim, input int pg,
		input int wr, input int mg, input int pbc);
		apb_write(REG_INDENT, ind);
		apb_write(REG_LINE, lim);
		apb_write(REG_PAGE, pg);
		apb_write(REG_WRAP, wr);
		apb_write(REG_MERGE, mg);
		apb_write(REG_PBCODE, pbc);
	endtask

	task automatic send_byte(input logic [7:0] b, input logic eot, input int want);
		int got;
		while (in_idle_pct > 0 && $urandom_range(99, 0) < in_idle_pct) @(negedge clk);
		in_valid = 1'b1;
		in_byte = b;
		end_of_text = eot;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		got = format_byte(b, eot);
		if (want >= 0 && got != want) begin
			$display("%0t: byte count for %h expected %0d actual %0d", $time, b, want, got);
			errors++;
		end
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic wait_idle();
		while (pending_bytes.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// output side: check and random stall
	always @(posedge clk) begin
		fmt_byte_t e;
		if (out_valid && !out_stall) begin
			if (pending_bytes.size() == 0) begin
				$display("%0t: unexpected byte expected none actual %h/%b",
					$time, out_byte, run_last);
				errors++;
			end else begin
				e = pending_bytes.pop_front();
				if (out_byte !== e.ch) begin
					$display("%0t: out_byte expected %h actual %h", $time, e.ch, out_byte);
					errors++;
				end
				if (run_last !== e.last) begin
					$display("%0t: run_last expected %b actual %b", $time, e.last, run_last);
					errors++;
				end
			end
		end
	end

	always @(negedge clk) begin
		out_stall <= (out_stall_pct > 0 && $urandom_range(99, 0) < out_stall_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_CYCLES) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic logic [7:0] pick_text_byte(input logic mode);
		int r;
		logic [7:0] punct [6] = '{"-", ",", ".", ":", 8'h22, 8'h27};
		r = $urandom_range(99, 0);
		if (mode) return 8'($urandom_range(255, 0));
		if (r < 55) return $urandom_range(1, 0) != 0 ? 8'($urandom_range("z", "a")) :
			8'($urandom_range("Z", "A"));
		if (r < 70) return CH_SPACE;
		if (r < 75) return punct[$urandom_range(5, 0)];
		if (r < 79) return CH_NL;
		if (r < 81) return CH_TAB;
		if (r < 84) return 8'hC3;
		if (r < 86) return 8'hE2;
		if (r < 88) return 8'hF0;
		if (r < 90) return 8'($urandom_range(8'hBF, 8'h80));
		return 8'($urandom_range(255, 0));
	endfunction

	task automatic random_text(input int count);
		logic [7:0] b;
		for (int i = 0; i < count; i++) begin
			b = pick_text_byte($urandom_range(9, 0) == 0);
			send_byte(b, $urandom_range(29, 0) == 0 || i == count - 1, -1);
		end
	endtask

	stim_row_t dir_rows [$];

	initial begin
		errors = 0;
		in_idle_pct = 0;
		out_stall_pct = 0;
		idle_cycles = 0;
		in_valid = 1'b0;
		in_byte = 8'h00;
		end_of_text = 1'b0;
		out_stall = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cfg_indent = 6'd4;
		cfg_line = 6'd62;
		cfg_page = 10'd50;
		cfg_wrap = 1'b1;
		cfg_merge = 1'b1;
		cfg_pbcode = 8'd12;
		clear_stream();
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// after reset: leading blanks and page-break byte dropped, "A" gets indent
		dir_rows = '{
			'{8'h20, 1'b0, 0}, '{8'h09, 1'b0, 0}, '{8'h0C, 1'b0, 0},
			'{"A", 1'b0, 4}, '{8'h20, 1'b0, 2}, '{8'h20, 1'b0, 0},
			'{8'h09, 1'b0, 1}, '{"b", 1'b0, 0}, '{"!", 1'b0, 2},
			'{8'h0A, 1'b0, 1}, '{8'h0A, 1'b0, 1}, '{8'h0A, 1'b0, 0},
			'{8'hC3, 1'b0, -1}, '{8'hA9, 1'b0, 1}, '{8'hE2, 1'b0, 1},
			'{8'h82, 1'b0, 1}, '{8'hAC, 1'b0, 1}, '{8'hF0, 1'b0, 1},
			'{8'h9F, 1'b0, 1}, '{8'hFF, 1'b0, 1}, '{8'hF8, 1'b0, -1},
			'{"x", 1'b0, 0}, '{8'hE2, 1'b1, -1}, '{8'h00, 1'b0, -1},
			'{8'h80, 1'b1, -1}
		};
		foreach (dir_rows[i]) send_byte(dir_rows[i].b, dir_rows[i].eot, dir_rows[i].want);
		wait_idle();

		// tight lines, paging every line, long word, no merge
		set_regs(0, 0, 1, 0, 0, 255);
		send_byte("q", 1'b0, -1);
		for (int i = 0; i < 20; i++) send_byte("w", 1'b0, -1);
		send_byte(8'hFF, 1'b0, -1);
		send_byte("z", 1'b1, -1);
		wait_idle();

		in_idle_pct = 0;
		out_stall_pct = 0;
		set_regs(63, 8, 3, 1, 1, 12);
		random_text(15);
		wait_idle();

		in_idle_pct = 53;
		set_regs(2, 62, 1023, 1, 0, 0);
		random_text(15);
		wait_idle();

		in_idle_pct = 0;
		out_stall_pct = 53;
		set_regs(1, 12, 0, 0, 1, 8'hC3);
		random_text(15);
		wait_idle();

		in_idle_pct = 28;
		out_stall_pct = 28;
		set_regs($urandom_range(62, 0), $urandom_range(40, 5), $urandom_range(4, 1),
			1, $urandom_range(1, 0), $urandom_range(255, 0));
		random_text(15);
		in_idle_pct = 0;
		out_stall_pct = 0;
		wait_idle();

		if (errors == 0 && pending_bytes.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== text_line_wrap_formatter.f =====
hdl/tlwf_pkg.sv
hdl/tlwf_word_ram.sv
hdl/text_line_wrap_formatter.sv
dv/text_line_wrap_formatter_tb.sv
